// ----- src/ost_pkg.sv -----
// Shared types and constants for the ordered set table.
package ost_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried in the action field of a request beat
    typedef enum logic [1:0] {
        ACT_QUERY  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT
    } t_state;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp;    // latch match against the request key
        logic valid;  // cell index below the entry count
        logic tail;   // cell index at or above the entry count
        logic load;   // write the request key into this cell
        logic del;    // start the shift-down wave at the matching cell
    } t_cell_ctl;

endpackage

// ----- src/ost_if.sv -----
// Request and response channel interfaces of the ordered set table.
interface ost_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         action;
    logic signed [ost_pkg::VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface ost_out_if;
    logic                        valid;
    logic                        ready;
    logic                        present;
    logic                        changed;
    logic                        full_res;
    logic [ost_pkg::COUNT_W-1:0] count;

    modport source (output valid, output present, output changed, output full_res,
                    output count, input ready);
    modport sink   (input valid, input present, input changed, input full_res,
                    input count, output ready);
endinterface

// ----- src/ost_cell.sv -----
// One table cell: holds an entry, matches it against a key, joins the shift wave.
module ost_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ost_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [ost_pkg::VALUE_W-1:0] i_key,
    input  logic signed [ost_pkg::VALUE_W-1:0] i_nbr_val,
    input  logic                               i_wave,
    output logic signed [ost_pkg::VALUE_W-1:0] o_val,
    output logic                               o_hit,
    output logic                               o_wave,
    output logic                               o_done
);

    logic signed [ost_pkg::VALUE_W-1:0] r_val;
    logic                               r_hit;
    logic                               r_wave;
    logic                               n_hit;
    logic                               n_wave;

    // match flag and wave token
    always_comb begin
        n_hit  = r_hit;
        if (i_ctl.cmp) begin
            n_hit = i_ctl.valid && (r_val == i_key);
        end
        n_wave = (i_ctl.del && r_hit) || i_wave;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_wave <= 1'b0;
        end else begin
            r_hit  <= n_hit;
            r_wave <= n_wave;
        end
    end

    // entry storage: append load or pull from upper neighbor while the wave sits here
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_key;
        end else if (r_wave && !i_ctl.tail) begin
            r_val <= i_nbr_val;
        end
    end

    assign o_val  = r_val;
    assign o_hit  = r_hit;
    assign o_wave = r_wave && !i_ctl.tail;
    assign o_done = r_wave && i_ctl.tail;

endmodule

// ----- src/ordered_set_table.sv -----
// Ordered set table: insertion-ordered set of distinct values in a row of cells.
// A request beat is taken only while idle; its response is registered from the
//   execute state once the response register is free or being read. A delete that
//   removes an entry holds the block in the shift state until the wave reaches the tail.
// The response register lets a new request in while the last response waits.
// Synchronous active-low reset empties the table; entry storage is not cleared.
module ordered_set_table #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ost_in_if.sink    i_req,
    ost_out_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ost_pkg::t_state                    r_state;
    ost_pkg::t_state                    n_state;
    ost_pkg::t_action                   r_action;
    logic signed [ost_pkg::VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;

    logic                               r_ov;
    logic                               n_ov;
    logic                               r_present;
    logic                               n_present;
    logic                               r_changed;
    logic                               n_changed;
    logic                               r_full;
    logic                               n_full;
    logic [ost_pkg::COUNT_W-1:0]        r_cnt_out;
    logic [ost_pkg::COUNT_W-1:0]        n_cnt_out;

    logic                               w_accept;
    logic                               w_go;
    logic                               w_do_ins;
    logic                               w_do_del;
    logic                               w_any;
    logic                               w_done_any;
    logic signed [ost_pkg::VALUE_W-1:0] w_key;

    ost_pkg::t_cell_ctl                 w_ctl  [CAPACITY];
    logic signed [ost_pkg::VALUE_W-1:0] w_val  [CAPACITY];
    logic signed [ost_pkg::VALUE_W-1:0] w_nbr  [CAPACITY];
    logic [CAPACITY-1:0]                w_hit;
    logic [CAPACITY-1:0]                w_wave;
    logic [CAPACITY-1:0]                w_win;
    logic [CAPACITY-1:0]                w_done;

    assign i_req.ready = (r_state == ost_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_any       = |w_hit;
    assign w_done_any  = |w_done;
    assign w_go        = !r_ov || o_rsp.ready;

    // compare against the live beat, append the held key
    assign w_key = (r_state == ost_pkg::S_IDLE) ? i_req.value : r_key;

    // row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        assign w_ctl[gi] = '{
            cmp:   w_accept,
            valid: (CNT_W'(gi) < r_count),
            tail:  (CNT_W'(gi) >= r_count),
            load:  w_do_ins && (r_count == CNT_W'(gi)),
            del:   w_do_del
        };

        if (gi == CAPACITY - 1) begin : g_last
            assign w_nbr[gi] = w_val[gi];
        end else begin : g_mid
            assign w_nbr[gi] = w_val[gi + 1];
        end

        if (gi == 0) begin : g_first
            assign w_win[gi] = 1'b0;
        end else begin : g_next
            assign w_win[gi] = w_wave[gi - 1];
        end

        ost_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[gi]),
            .i_key     (w_key),
            .i_nbr_val (w_nbr[gi]),
            .i_wave    (w_win[gi]),
            .o_val     (w_val[gi]),
            .o_hit     (w_hit[gi]),
            .o_wave    (w_wave[gi]),
            .o_done    (w_done[gi])
        );
    end

    // sequencer state and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ost_pkg::S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // request opcode, key and response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= ost_pkg::t_action'(i_req.action);
            r_key    <= i_req.value;
        end
        r_present <= n_present;
        r_changed <= n_changed;
        r_full    <= n_full;
        r_cnt_out <= n_cnt_out;
    end

    // next state, table update and response
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ov      = r_ov && !o_rsp.ready;
        n_present = r_present;
        n_changed = r_changed;
        n_full    = r_full;
        n_cnt_out = r_cnt_out;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;

        unique case (r_state)
            ost_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = ost_pkg::S_EXEC;
                end
            end
            ost_pkg::S_EXEC: begin
                if (w_go) begin
                    n_ov      = 1'b1;
                    n_present = w_any;
                    n_changed = 1'b0;
                    n_full    = 1'b0;
                    unique case (r_action)
                        ost_pkg::ACT_INSERT: begin
                            if (!w_any) begin
                                if (r_count < CNT_W'(CAPACITY)) begin
                                    w_do_ins  = 1'b1;
                                    n_count   = r_count + 1'b1;
                                    n_changed = 1'b1;
                                end else begin
                                    n_full = 1'b1;
                                end
                            end
                        end
                        ost_pkg::ACT_DELETE: begin
                            if (w_any) begin
                                w_do_del  = 1'b1;
                                n_count   = r_count - 1'b1;
                                n_changed = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_cnt_out = ost_pkg::COUNT_W'(n_count);
                    n_state   = w_do_del ? ost_pkg::S_SHIFT : ost_pkg::S_IDLE;
                end
            end
            ost_pkg::S_SHIFT: begin
                if (w_done_any) begin
                    n_state = ost_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ost_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid    = r_ov;
    assign o_rsp.present  = r_present;
    assign o_rsp.changed  = r_changed;
    assign o_rsp.full_res = r_full;
    assign o_rsp.count    = r_cnt_out;

    // count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // held values are distinct, so at most one cell matches
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matched");

    // a single shift wave at a time
    a_wave_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wave | w_done))
        else $error("more than one shift wave token");

    // response count reflects the table after the step
    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ost_pkg::S_EXEC && w_go) |=>
            (o_rsp.valid && o_rsp.count == ost_pkg::COUNT_W'(r_count)))
        else $error("response count differs from table count");

    // a wave runs only while the sequencer is shifting
    a_wave_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|(w_wave | w_done)) |-> (r_state == ost_pkg::S_SHIFT))
        else $error("shift wave outside shift state");

endmodule
